FILE: hw/rtl/cqs_pkg.sv
package cqs_pkg;

	// fixed field widths of the stream items
	localparam int VALUE_W     = 32;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int OCC_W       = 4;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_SEARCH = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	// which result the output register takes
	typedef enum logic [1:0] {
		OUT_PLAIN  = 2'd0,
		OUT_POP    = 2'd1,
		OUT_SEARCH = 2'd2
	} out_kind_t;

	typedef struct packed {
		logic      push;        // write at tail, advance tail, count up
		logic      pop;         // read at head, advance head, count down
		logic      srch_start;  // latch key, scan from head over count entries
		logic      scan_step;   // issue next scan read
		logic      rd_scan;     // read address: scan pointer instead of head
		logic      out_load;    // load the output register
		out_kind_t out_kind;
		status_t   out_status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_done;
		logic out_valid;
	} stat_t;

endpackage

FILE: hw/rtl/cqs_ctrl.sv
module cqs_ctrl import cqs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  mode_t in_mode,
	input  logic  out_ready,
	output logic  in_ready,
	output cmd_t  cmd,
	input  stat_t stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_WAIT,
		ST_SEARCH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && (!stat.out_valid || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd        = '0;
		cmd.out_kind   = OUT_PLAIN;
		cmd.out_status = STAT_OK;
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_mode)
						MODE_PUSH: begin
							cmd.out_load = 1'b1;
							if (stat.full) begin
								cmd.out_status = STAT_OVERFLOW;
							end else begin
								cmd.push = 1'b1;
							end
						end
						MODE_POP: begin
							if (stat.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = STAT_UNDERFLOW;
							end else begin
								cmd.pop = 1'b1;
								state_d = ST_POP_WAIT;
							end
						end
						MODE_SEARCH: begin
							if (stat.empty) begin
								cmd.out_load = 1'b1;
							end else begin
								cmd.srch_start = 1'b1;
								state_d        = ST_SEARCH;
							end
						end
						default: begin
							cmd.out_load = 1'b1;
						end
					endcase
				end
			end
			ST_POP_WAIT: begin
				cmd.out_load = 1'b1;
				cmd.out_kind = OUT_POP;
				state_d      = ST_IDLE;
			end
			ST_SEARCH: begin
				cmd.scan_step = 1'b1;
				cmd.rd_scan   = 1'b1;
				if (stat.scan_done) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_SEARCH;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/cqs_dp.sv
module cqs_dp import cqs_pkg::*; #(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output stat_t                     stat,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [OUT_TDATA_W-1:0]    out_tdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [AW-1:0]         scan_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [CW-1:0]         left_q;
	logic                  rv_s1;
	logic [DATA_WIDTH-1:0] key_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [AW-1:0]         rd_addr;
	logic [63:0]           value_ext;
	logic [DATA_WIDTH-1:0] word;
	logic signed [63:0]    rd_ext;
	logic                  hit;

	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  out_data_q;
	logic                       out_found_q;
	status_t                    out_status_q;
	logic [OCC_W-1:0]           out_occ_q;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
		logic [AW-1:0] nxt;
		if (idx == AW'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = idx + 1'b1;
		end
		return nxt;
	endfunction

	// stored word: low bits of the value, zero above 32 bits
	assign value_ext = {32'b0, value};
	assign word      = value_ext[DATA_WIDTH-1:0];
	assign rd_ext    = 64'($signed(rd_q));
	assign rd_addr   = cmd.rd_scan ? scan_q : head_q;
	assign hit       = rv_s1 && (rd_q == key_q);

	always_comb begin
		count_d = count_q;
		if (cmd.push) begin
			count_d = count_q + 1'b1;
		end else if (cmd.pop) begin
			count_d = count_q - 1'b1;
		end
	end

	assign stat.full      = (count_q == CW'(DEPTH));
	assign stat.empty     = (count_q == '0);
	assign stat.scan_done = hit || ((left_q == '0) && !rv_s1);
	assign stat.out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= word;
		end
		rd_q <= mem[rd_addr];
		if (cmd.srch_start) begin
			key_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			scan_q  <= '0;
			left_q  <= '0;
			rv_s1   <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.push) begin
				tail_q <= next_slot(tail_q);
			end
			if (cmd.pop) begin
				head_q <= next_slot(head_q);
			end
			rv_s1 <= cmd.scan_step && (left_q != '0);
			if (cmd.srch_start) begin
				scan_q <= head_q;
				left_q <= count_q;
			end else if (cmd.scan_step && (left_q != '0)) begin
				scan_q <= next_slot(scan_q);
				left_q <= left_q - 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_occ_q    <= OCC_W'(count_d);
			out_data_q   <= (cmd.out_kind == OUT_POP) ? rd_ext[VALUE_W-1:0] : '0;
			out_found_q  <= (cmd.out_kind == OUT_SEARCH) ? hit : 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tdata = {1'b0, out_occ_q, out_status_q, out_found_q, out_data_q};

endmodule

FILE: hw/rtl/circular_queue_with_search_unit.sv
// circular queue with search: a ring-buffer fifo of DEPTH words of DATA_WIDTH bits
// input stream (s_*): one transfer per operation, s_tuser is the mode
//   push stores s_tdata at the tail, pop returns the oldest word,
//   search reports whether s_tdata matches any word now held
// output stream (m_*): exactly one result transfer per input transfer, in order
// how the result reaches the output register:
//   push, full/empty special cases, unused mode: loaded directly on the input transfer
//   pop: a registered memory read of the head slot, then the output register
//   search: one stored entry read and compared per cycle through the single
//   memory read port; the scan stops at the first match or after every held
//   entry is read, and the result is then loaded into the output register
// one operation is in flight at a time; the next input transfer is taken in the
// idle state once the output register is empty or being emptied, so with a
// ready receiver only the pop read and the search scan hold off the next transfer
// reset clears head, tail and count: the queue comes up empty with no output
// pending; stored words need no clearing since only written slots are read
// a stalled receiver (m_tready low) holds the result in the output register and
// blocks further input transfers until it is taken
module circular_queue_with_search_unit import cqs_pkg::*; #(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [VALUE_W-1:0]     s_tdata,   // [31:0] value
	input  logic [MODE_W-1:0]      s_tuser,   // [1:0] mode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // [31:0] data, [32] found,
	                                          // [34:33] status, [38:35] occupancy
);

	cmd_t  cmd;
	stat_t stat;

	// controller: sequences push, pop and the search scan
	cqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_mode   (mode_t'(s_tuser)),
		.out_ready (m_tready),
		.in_ready  (s_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath: entry memory, pointers, count, scan and output register
	cqs_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.value     ($signed(s_tdata)),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_tdata (m_tdata)
	);

endmodule

FILE: test/cqs_result_checker.sv
module cqs_result_checker import cqs_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [VALUE_W-1:0]     s_tdata,   // [31:0] value
	input  logic [MODE_W-1:0]      s_tuser,   // [1:0] mode
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] data, [32] found,
	                                          // [34:33] status, [38:35] occupancy
	output int                     mismatch_count,
	output int                     results_owed
);

	// same layout as the low bits of m_tdata
	typedef struct packed {
		logic [OCC_W-1:0]   occupancy;
		status_t            status;
		logic               found;
		logic [VALUE_W-1:0] data;
	} queue_result_t;

	logic [VALUE_W-1:0] words [DEPTH];
	int                 head_slot;
	int                 tail_slot;
	int                 held;
	queue_result_t      owed_results [$];
	queue_result_t      want;
	queue_result_t      got;

	// applies one operation to the shadow queue and returns its result
	function automatic queue_result_t apply_op(mode_t mode, logic [VALUE_W-1:0] value);
		queue_result_t r;
		int            slot;
		int            n;
		r = '0;
		case (mode)
			MODE_PUSH: begin
				if (held == DEPTH) begin
					r.status = STAT_OVERFLOW;
				end else begin
					words[tail_slot] = value;
					tail_slot = (tail_slot + 1) % DEPTH;
					held++;
				end
			end
			MODE_POP: begin
				if (held == 0) begin
					r.status = STAT_UNDERFLOW;
				end else begin
					r.data = words[head_slot];
					head_slot = (head_slot + 1) % DEPTH;
					held--;
				end
			end
			MODE_SEARCH: begin
				slot = head_slot;
				for (n = 0; n < held; n++) begin
					if (words[slot] == value)
						r.found = 1'b1;
					slot = (slot + 1) % DEPTH;
				end
			end
			default: ;
		endcase
		r.occupancy = held[OCC_W-1:0];
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot = 0;
			tail_slot = 0;
			held      = 0;
			owed_results.delete();
		end else begin
			// record first so a result in the same cycle still finds its entry
			if (s_tvalid && s_tready)
				owed_results.push_back(apply_op(mode_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result transfer %0h with nothing expected", $time, m_tdata);
					mismatch_count++;
				end else begin
					want = owed_results.pop_front();
					got  = m_tdata[$bits(queue_result_t)-1:0];
					compare_field("data", want.data, got.data);
					compare_field("found", 32'(want.found), 32'(got.found));
					compare_field("status", 32'(want.status), 32'(got.status));
					compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
				end
			end
		end
		results_owed = owed_results.size();
	end

endmodule

FILE: test/circular_queue_with_search_unit_tb.sv
module circular_queue_with_search_unit_tb;
	import cqs_pkg::*;

	localparam int DEPTH       = 8;
	localparam int DATA_WIDTH  = 32;
	localparam int QUIET_LIMIT = 2000;  // cycles with no transfer on either side
	localparam int RANDOM_OPS  = 450;   // per idling phase, four phases

	// the mode code the block treats as a no-op
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [VALUE_W-1:0]     s_tdata  = '0;   // [31:0] value
	logic [MODE_W-1:0]      s_tuser  = '0;   // [1:0] mode
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [31:0] data, [32] found,
	                                         // [34:33] status, [38:35] occupancy

	int mismatch_count;
	int results_owed;
	int quiet_cycles = 0;

	// chances in percent, changed per phase
	int idle_pct  = 0;
	int stall_pct = 0;

	// recently pushed words, so searches hit as well as miss
	logic [VALUE_W-1:0] recent_words [$];

	circular_queue_with_search_unit #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	cqs_result_checker #(
		.DEPTH (DEPTH)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver side: stalls at random with the phase's chance
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog: too long without any transfer means the block hung
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("circular_queue_with_search_unit_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// mostly random words, now and then an extreme or the old sentinel value
	function automatic logic [VALUE_W-1:0] pick_word();
		case ($urandom_range(15))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			4:       return 32'hffff_d8f1;  // -9999
			default: return $urandom();
		endcase
	endfunction

	// one input transfer; called and returning at a falling edge
	task automatic send_op(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
		// sender gaps, with noise on the data lines while idle
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom();
			s_tuser  <= MODE_W'($urandom_range(3));
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (mode == MODE_PUSH) begin
			recent_words.push_back(value);
			if (recent_words.size() > 12)
				void'(recent_words.pop_front());
		end
	endtask

	initial begin
		int                 phase;
		int                 n;
		int                 roll;
		int                 push_bias;
		logic [MODE_W-1:0]  op;
		logic [VALUE_W-1:0] word;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty-queue cases first
		send_op(MODE_SEARCH, 32'h0000_0000);
		send_op(MODE_POP, 32'hffff_ffff);       // underflow, value ignored
		send_op(MODE_UNUSED, 32'h1234_5678);    // no-op on empty queue

		// fill with the extremes and the old sentinel value
		send_op(MODE_PUSH, 32'h8000_0000);
		send_op(MODE_PUSH, 32'h7fff_ffff);
		send_op(MODE_PUSH, 32'h0000_0000);
		send_op(MODE_PUSH, 32'hffff_ffff);
		send_op(MODE_PUSH, 32'hffff_d8f1);
		send_op(MODE_PUSH, 32'h0000_0001);
		send_op(MODE_PUSH, 32'h5555_5555);
		send_op(MODE_PUSH, 32'haaaa_aaaa);

		// full queue: overflow, then searches at head, tail and a miss
		send_op(MODE_PUSH, 32'h0bad_cafe);
		send_op(MODE_SEARCH, 32'haaaa_aaaa);
		send_op(MODE_SEARCH, 32'h8000_0000);
		send_op(MODE_SEARCH, 32'h0bad_cafe);
		send_op(MODE_UNUSED, 32'h0000_0000);

		// drain in order, then pop past empty and search the sentinel
		for (n = 0; n < DEPTH; n++)
			send_op(MODE_POP, 32'h0000_0000);
		send_op(MODE_POP, 32'h0000_0000);
		send_op(MODE_SEARCH, 32'hffff_d8f1);

		// random part: no idling, sender idle, receiver stalling, both
		push_bias = 50;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 67; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 67; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			for (n = 0; n < RANDOM_OPS; n++) begin
				// swing the push/pop balance so the queue runs full and empty
				if (n % 24 == 0)
					push_bias = 25 * $urandom_range(1, 3);
				roll = $urandom_range(99);
				word = pick_word();
				if (roll < 3) begin
					op = MODE_UNUSED;
				end else if (roll < 28) begin
					op = MODE_SEARCH;
					if (recent_words.size() != 0 && $urandom_range(9) < 7)
						word = recent_words[$urandom_range(recent_words.size() - 1)];
				end else if ($urandom_range(99) < push_bias) begin
					op = MODE_PUSH;
					// duplicates now and then, so a search meets repeated words
					if (recent_words.size() != 0 && $urandom_range(9) < 2)
						word = recent_words[$urandom_range(recent_words.size() - 1)];
				end else begin
					op = MODE_POP;
				end
				send_op(op, word);
			end
		end

		// wait for every owed result, then wait on for stray transfers
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (results_owed != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("circular_queue_with_search_unit_tb: clean");
		end else begin
			$display("circular_queue_with_search_unit_tb: errors");
		end
		$finish;
	end

endmodule
